>>> hdl/bas_pkg.sv
// ---------------------------------------------------------------------------
// bas_pkg
// Shared types, codes and constants of the bridge ADC serial reader.
// ---------------------------------------------------------------------------
package bas_pkg;

  localparam int SAMPLE_BITS_DEF = 24;

  localparam int GAIN_W    = 2;
  localparam int TMO_W     = 32;
  localparam int OFS_W     = 24;
  localparam int SCALE_W   = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam int OP_W     = 2;
  localparam int CNT_W    = 8;
  localparam int SUM_W    = 32;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 48;

  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 32;

  // opcodes
  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_MEASURE = 2'd1;
  localparam logic [OP_W-1:0] OP_TARE    = 2'd2;
  localparam logic [OP_W-1:0] OP_RAW     = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_TIMEOUT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FAIL    = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 2'd3;

  // register reset values
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 2'd1;
  localparam logic [TMO_W-1:0]   TMO_RESET   = 32'd500000;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

  localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAIT,
    ST_SHIFT,
    ST_AVG,
    ST_SCALE
  } state_t;

  typedef enum logic [1:0] {
    SEL_TICK,
    SEL_TIMEOUT,
    SEL_AVG,
    SEL_SCALE
  } out_sel_t;

  typedef struct packed {
    logic     start;
    logic     wait_inc;
    logic     shift_clr;
    logic     tick_high;
    logic     tick_low;
    logic     sample_end;
    logic     avg_start;
    logic     scale_start;
    logic     out_load;
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic tmo_zero;
    logic wait_expired;
    logic tick_is_high;
    logic tick_last;
    logic samples_last;
    logic is_measure;
    logic scale_zero;
  } stat_t;

endpackage

>>> hdl/bas_div.sv
// ---------------------------------------------------------------------------
// bas_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bas_div #(
  parameter int NUM_W = bas_pkg::DIV_NUM_W,
  parameter int DEN_W = bas_pkg::DIV_DEN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      steps <= STEP_W'(NUM_W);
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], fits};
      rem <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    end
  end

endmodule

>>> hdl/bas_datapath.sv
// ---------------------------------------------------------------------------
// bas_datapath
// Config registers, shift and accumulate logic, result math, output word.
// ---------------------------------------------------------------------------
module bas_datapath #(
  parameter int SAMPLE_BITS = bas_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bas_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bas_pkg::CFG_W-1:0]       cfg_data,
  input  logic [bas_pkg::OP_W-1:0]        opcode,
  input  logic                            dout_level,
  input  logic [bas_pkg::CNT_W-1:0]       sample_count,
  input  bas_pkg::cmd_t                   cmd,
  output bas_pkg::stat_t                  stat,
  output logic                            div_start,
  output logic [bas_pkg::DIV_NUM_W-1:0]   div_num,
  output logic [bas_pkg::DIV_DEN_W-1:0]   div_den,
  input  logic [bas_pkg::DIV_NUM_W-1:0]   div_quo,
  input  logic                            m_tready,
  output logic                            out_valid,
  output logic                            out_sck,
  output logic                            out_done,
  output logic [bas_pkg::STATUS_W-1:0]    out_status,
  output logic [bas_pkg::VALUE_W-1:0]     out_value
);

  localparam int TICK_W = $clog2(2 * (SAMPLE_BITS + 3) + 1);
  localparam logic [TICK_W:0] DATA_TICKS = (TICK_W+1)'(2 * SAMPLE_BITS);
  localparam int SUM_W   = bas_pkg::SUM_W;
  localparam int OFS_W   = bas_pkg::OFS_W;
  localparam int VALUE_W = bas_pkg::VALUE_W;
  localparam int HALF_W  = bas_pkg::DIV_NUM_W - SUM_W;

  logic [bas_pkg::GAIN_W-1:0]  gain;
  logic [bas_pkg::TMO_W-1:0]   tmo;
  logic [bas_pkg::SCALE_W-1:0] scale;
  logic [OFS_W-1:0]            active_offset;

  logic [bas_pkg::OP_W-1:0]  pending;
  logic [bas_pkg::CNT_W-1:0] target;
  logic [SUM_W-1:0]          sample_sum;
  logic [bas_pkg::CNT_W-1:0] samples_taken;
  logic [bas_pkg::TMO_W-1:0] wait_count;
  logic [TICK_W-1:0]         tick_count;
  logic [SAMPLE_BITS-1:0]    shift_word;
  logic                      avg_neg;
  logic                      res_neg;

  logic [TICK_W:0]              total_ticks;
  logic [SUM_W-1:0]             sample_ext;
  logic [SUM_W-1:0]             sum_next;
  logic [SUM_W-1:0]             sum_mag;
  logic [SUM_W-1:0]             avg;
  logic [SUM_W:0]               diff;
  logic [SUM_W:0]               diff_mag;
  logic [bas_pkg::SCALE_W-1:0]  scale_mag;
  logic [VALUE_W-1:0]           scaled;
  logic                         q_over_pos;
  logic                         q_over_neg;

  logic                         sck_next;
  logic                         done_next;
  logic [bas_pkg::STATUS_W-1:0] status_next;
  logic [VALUE_W-1:0]           value_next;

  // ---- status toward the controller ----
  assign total_ticks = DATA_TICKS + (TICK_W+1)'({gain, 1'b0});

  assign stat.tmo_zero     = (tmo == '0);
  assign stat.wait_expired = ({1'b0, wait_count} + 1'b1) >= {1'b0, tmo};
  assign stat.tick_is_high = ~tick_count[0];
  assign stat.tick_last    = ({1'b0, tick_count} + 1'b1) >= total_ticks;
  assign stat.samples_last = ({1'b0, samples_taken} + 1'b1) >= {1'b0, target};
  assign stat.is_measure   = (pending == bas_pkg::OP_MEASURE);
  assign stat.scale_zero   = (scale == '0);

  // ---- arithmetic ----
  assign sample_ext = {{(SUM_W-SAMPLE_BITS){shift_word[SAMPLE_BITS-1]}}, shift_word};
  assign sum_next   = sample_sum + sample_ext;
  assign sum_mag    = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : sum_next;

  // divider quotient holds |sum| / count while the average is current
  assign avg = avg_neg ? SUM_W'(-div_quo[SUM_W-1:0]) : div_quo[SUM_W-1:0];

  assign diff      = {avg[SUM_W-1], avg} - (SUM_W+1)'($signed(active_offset));
  assign diff_mag  = diff[SUM_W] ? (SUM_W+1)'(-diff) : diff;
  assign scale_mag = scale[bas_pkg::SCALE_W-1] ? bas_pkg::SCALE_W'(-scale) : scale;

  assign div_start = cmd.avg_start | cmd.scale_start;
  always_comb begin
    if (cmd.scale_start) begin
      div_num = {diff_mag[SUM_W-1:0], {HALF_W{1'b0}}};
      div_den = scale_mag;
    end else begin
      div_num = bas_pkg::DIV_NUM_W'(sum_mag);
      div_den = bas_pkg::DIV_DEN_W'(target);
    end
  end

  // saturation of the Q32.16 quotient
  assign q_over_pos = (div_quo[bas_pkg::DIV_NUM_W-1:VALUE_W-1] != '0);
  assign q_over_neg = (div_quo[bas_pkg::DIV_NUM_W-1:VALUE_W] != '0) ||
                      (div_quo[VALUE_W-1] && (div_quo[VALUE_W-2:0] != '0));
  always_comb begin
    if (res_neg) begin
      scaled = q_over_neg ? bas_pkg::VAL_MIN : VALUE_W'(-div_quo[VALUE_W-1:0]);
    end else begin
      scaled = q_over_pos ? bas_pkg::VAL_MAX : div_quo[VALUE_W-1:0];
    end
  end

  // ---- output word select ----
  always_comb begin
    sck_next    = 1'b0;
    done_next   = 1'b0;
    status_next = bas_pkg::STAT_OK;
    value_next  = '0;
    case (cmd.out_sel)
      bas_pkg::SEL_TICK: begin
        sck_next = cmd.tick_high;
      end
      bas_pkg::SEL_TIMEOUT: begin
        done_next   = 1'b1;
        status_next = bas_pkg::STAT_TIMEOUT;
      end
      bas_pkg::SEL_AVG: begin
        done_next = 1'b1;
        if (pending == bas_pkg::OP_TARE) begin
          value_next = VALUE_W'($signed(avg[OFS_W-1:0]));
        end else if (pending == bas_pkg::OP_RAW) begin
          value_next = VALUE_W'($signed(avg));
        end else begin
          status_next = bas_pkg::STAT_FAIL;
        end
      end
      bas_pkg::SEL_SCALE: begin
        done_next  = 1'b1;
        value_next = scaled;
      end
      default: begin
        sck_next = 1'b0;
      end
    endcase
  end

  // ---- config registers and offset ----
  always_ff @(posedge clk) begin
    if (rst) begin
      gain          <= bas_pkg::GAIN_RESET;
      tmo           <= bas_pkg::TMO_RESET;
      scale         <= bas_pkg::SCALE_RESET;
      active_offset <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bas_pkg::REG_GAIN:    gain          <= cfg_data[bas_pkg::GAIN_W-1:0];
          bas_pkg::REG_TIMEOUT: tmo           <= cfg_data[bas_pkg::TMO_W-1:0];
          bas_pkg::REG_OFFSET:  active_offset <= cfg_data[OFS_W-1:0];
          bas_pkg::REG_SCALE:   scale         <= cfg_data[bas_pkg::SCALE_W-1:0];
          default: begin
            gain <= gain;
          end
        endcase
      end
      if (cmd.out_load && cmd.out_sel == bas_pkg::SEL_AVG &&
          pending == bas_pkg::OP_TARE) begin
        active_offset <= avg[OFS_W-1:0];
      end
    end
  end

  // ---- conversion state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      pending       <= '0;
      target        <= '0;
      sample_sum    <= '0;
      samples_taken <= '0;
      wait_count    <= '0;
      tick_count    <= '0;
      shift_word    <= '0;
      avg_neg       <= 1'b0;
      res_neg       <= 1'b0;
    end else begin
      if (cmd.start) begin
        pending       <= opcode;
        target        <= (sample_count == '0) ? bas_pkg::CNT_W'(1) : sample_count;
        sample_sum    <= '0;
        samples_taken <= '0;
        wait_count    <= '0;
        tick_count    <= '0;
        shift_word    <= '0;
      end
      if (cmd.wait_inc) begin
        wait_count <= wait_count + 1'b1;
      end
      if (cmd.shift_clr) begin
        tick_count <= '0;
        shift_word <= '0;
      end
      if (cmd.tick_high) begin
        // gain pulses past the data bits clock nothing in
        if ({1'b0, tick_count} < DATA_TICKS) begin
          shift_word <= {shift_word[SAMPLE_BITS-2:0], dout_level};
        end
        tick_count <= tick_count + 1'b1;
      end
      if (cmd.tick_low) begin
        tick_count <= tick_count + 1'b1;
      end
      if (cmd.sample_end) begin
        sample_sum    <= sum_next;
        samples_taken <= samples_taken + 1'b1;
        tick_count    <= '0;
        shift_word    <= '0;
        wait_count    <= '0;
      end
      if (cmd.avg_start) begin
        avg_neg <= sum_next[SUM_W-1];
      end
      if (cmd.scale_start) begin
        res_neg <= diff[SUM_W] ^ scale[bas_pkg::SCALE_W-1];
      end
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sck    <= sck_next;
      out_done   <= done_next;
      out_status <= status_next;
      out_value  <= value_next;
    end
  end

endmodule

>>> hdl/bas_ctrl.sv
// ---------------------------------------------------------------------------
// bas_ctrl
// Command sequencer: wait, clock-out, accumulate and divide phases.
// ---------------------------------------------------------------------------
module bas_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [bas_pkg::OP_W-1:0] opcode,
  input  logic                     dout_level,
  input  logic                     out_free,
  input  logic                     div_done,
  input  bas_pkg::stat_t           stat,
  output bas_pkg::cmd_t            cmd
);

  bas_pkg::state_t state;
  bas_pkg::state_t state_next;
  logic            in_acc;

  assign in_ready = out_free && (state == bas_pkg::ST_IDLE ||
                                 state == bas_pkg::ST_WAIT ||
                                 state == bas_pkg::ST_SHIFT);
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bas_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bas_pkg::ST_IDLE: begin
        if (in_acc && opcode != bas_pkg::OP_TICK) state_next = bas_pkg::ST_WAIT;
      end
      bas_pkg::ST_WAIT: begin
        if (in_acc) begin
          if (!stat.tmo_zero && !dout_level) begin
            state_next = bas_pkg::ST_SHIFT;
          end else if (stat.tmo_zero || stat.wait_expired) begin
            state_next = bas_pkg::ST_IDLE;
          end
        end
      end
      bas_pkg::ST_SHIFT: begin
        if (in_acc && !stat.tick_is_high && stat.tick_last) begin
          state_next = stat.samples_last ? bas_pkg::ST_AVG : bas_pkg::ST_WAIT;
        end
      end
      bas_pkg::ST_AVG: begin
        if (div_done) begin
          if (stat.is_measure && !stat.scale_zero) begin
            state_next = bas_pkg::ST_SCALE;
          end else if (out_free) begin
            state_next = bas_pkg::ST_IDLE;
          end
        end
      end
      bas_pkg::ST_SCALE: begin
        if (div_done && out_free) state_next = bas_pkg::ST_IDLE;
      end
      default: begin
        state_next = bas_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.out_sel = bas_pkg::SEL_TICK;
    case (state)
      bas_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmd.out_load = 1'b1;
          cmd.start    = (opcode != bas_pkg::OP_TICK);
        end
      end
      bas_pkg::ST_WAIT: begin
        if (in_acc) begin
          cmd.out_load = 1'b1;
          if (!stat.tmo_zero && !dout_level) begin
            cmd.shift_clr = 1'b1;
          end else if (stat.tmo_zero || stat.wait_expired) begin
            cmd.out_sel = bas_pkg::SEL_TIMEOUT;
          end else begin
            cmd.wait_inc = 1'b1;
          end
        end
      end
      bas_pkg::ST_SHIFT: begin
        if (in_acc) begin
          if (stat.tick_is_high) begin
            cmd.tick_high = 1'b1;
            cmd.out_load  = 1'b1;
          end else if (stat.tick_last) begin
            cmd.sample_end = 1'b1;
            // last sample: word is held back until the divides finish
            cmd.avg_start  = stat.samples_last;
            cmd.out_load   = !stat.samples_last;
          end else begin
            cmd.tick_low = 1'b1;
            cmd.out_load = 1'b1;
          end
        end
      end
      bas_pkg::ST_AVG: begin
        if (div_done) begin
          if (stat.is_measure && !stat.scale_zero) begin
            cmd.scale_start = 1'b1;
          end else if (out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = bas_pkg::SEL_AVG;
          end
        end
      end
      bas_pkg::ST_SCALE: begin
        if (div_done && out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = bas_pkg::SEL_SCALE;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("output word overwritten before it was taken");

  a_avg_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.avg_start |=> (state == bas_pkg::ST_AVG && !div_done))
    else $error("average divide not tracked after start");

  a_scale_guard: assert property (@(posedge clk) disable iff (rst)
    cmd.scale_start |-> (stat.is_measure && !stat.scale_zero))
    else $error("scale divide started without a nonzero scale");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> state == bas_pkg::ST_WAIT)
    else $error("command start did not enter the wait phase");
`endif

endmodule

>>> hdl/bridge_adc_serial_reader.sv
// ---------------------------------------------------------------------------
// bridge_adc_serial_reader
// Serial bridge-converter reader: one half-bit tick per input word, averaging
// conversions and scaling the result.
//
//   channel  dir  handshake          payload
//   s_*      in   tvalid/tready      tuser: opcode; tdata: dout_level, sample_count
//   m_*      out  tvalid/tready      tdata: sck_level, value; tlast: done_res;
//                                    tuser: status
//   cfg_*    in   cfg_we             cfg_index, cfg_data
//
// Each tick word returns one word in the output register.
// The tick that ends the last sample of a command is followed by a 64-step
// divide for the average, plus a second 64-step divide for measure when the
// scale is nonzero; both run on the shared restoring divider, and s_tready
// stays low meanwhile.
// s_tready is also low while the output word is held and m_tready is low.
// Synchronous reset; no clearing pass.
// ---------------------------------------------------------------------------
module bridge_adc_serial_reader #(
  parameter int SAMPLE_BITS = bas_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bas_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // [0] dout_level, [8:1] sample_count
  input  logic [1:0]                    s_tuser,   // [1:0] opcode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [55:0]                   m_tdata,   // [0] sck_level, [48:1] value
  output logic                          m_tlast,   // done_res
  output logic [1:0]                    m_tuser    // [1:0] status
);

  bas_pkg::cmd_t                   cmd;
  bas_pkg::stat_t                  stat;
  logic                            out_free;
  logic                            div_start;
  logic                            div_done;
  logic [bas_pkg::DIV_NUM_W-1:0]   div_num;
  logic [bas_pkg::DIV_DEN_W-1:0]   div_den;
  logic [bas_pkg::DIV_NUM_W-1:0]   div_quo;
  logic                            out_sck;
  logic [bas_pkg::VALUE_W-1:0]     out_value;

  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {7'b0, out_value, out_sck};

  bas_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .opcode     (s_tuser),
    .dout_level (s_tdata[0]),
    .out_free   (out_free),
    .div_done   (div_done),
    .stat       (stat),
    .cmd        (cmd)
  );

  bas_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .opcode       (s_tuser),
    .dout_level   (s_tdata[0]),
    .sample_count (s_tdata[8:1]),
    .cmd          (cmd),
    .stat         (stat),
    .div_start    (div_start),
    .div_num      (div_num),
    .div_den      (div_den),
    .div_quo      (div_quo),
    .m_tready     (m_tready),
    .out_valid    (m_tvalid),
    .out_sck      (out_sck),
    .out_done     (m_tlast),
    .out_status   (m_tuser),
    .out_value    (out_value)
  );

  bas_div #(
    .NUM_W (bas_pkg::DIV_NUM_W),
    .DEN_W (bas_pkg::DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

endmodule
